// File: hdl/psd_pkg.sv
package psd_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    typedef enum logic [1:0] {
        KIND_INTERIOR = 2'd0,
        KIND_START    = 2'd1,
        KIND_END      = 2'd2,
        KIND_DEGEN    = 2'd3
    } kind_t;

endpackage

// File: hdl/psd_front.sv
module psd_front import psd_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int LW         = 2 * COORD_BITS + 2,
    parameter int QW         = 2 * COORD_BITS + 3 + 2 * FRAC_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] sx,
    input  logic signed [COORD_BITS-1:0] sy,
    input  logic signed [COORD_BITS-1:0] ex,
    input  logic signed [COORD_BITS-1:0] ey,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [LW-1:0]                out_rem,
    output logic [QW-1:0]                out_work,
    output logic [LW-1:0]                out_den,
    output kind_t                        out_kind
);

    localparam int DW   = COORD_BITS + 1;
    localparam int PW   = 2 * DW;
    localparam int SW   = PW + 1;
    localparam int CRW  = 2 * COORD_BITS + 1;
    localparam int LO   = COORD_BITS + 1;
    localparam int HI   = CRW - LO;
    localparam int NBW  = 2 * CRW;
    localparam int NW   = QW + LW;
    localparam int NST  = 6;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] rdy;
    logic [NST-1:0] vin;

    always_comb begin
        rdy[NST-1] = !v_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        vin[0] = in_valid;
        for (int i = 1; i < NST; i++) begin
            vin[i] = v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (rdy[i]) v_reg[i] <= vin[i];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NST-1];

    // stage 1: differences
    logic signed [DW-1:0] dx_reg, dy_reg, ax_reg, ay_reg, bx_reg, by_reg;

    always_ff @(posedge aclk) begin
        if (rdy[0] && vin[0]) begin
            dx_reg <= DW'(ex) - DW'(sx);
            dy_reg <= DW'(ey) - DW'(sy);
            ax_reg <= DW'(px) - DW'(sx);
            ay_reg <= DW'(py) - DW'(sy);
            bx_reg <= DW'(px) - DW'(ex);
            by_reg <= DW'(py) - DW'(ey);
        end
    end

    // stage 2: products
    logic signed [PW-1:0] pdx_reg, pdy_reg, pax_reg, pay_reg, pca_reg, pcb_reg;
    logic signed [PW-1:0] qax_reg, qay_reg, qbx_reg, qby_reg;

    always_ff @(posedge aclk) begin
        if (rdy[1] && vin[1]) begin
            pdx_reg <= PW'(dx_reg) * PW'(dx_reg);
            pdy_reg <= PW'(dy_reg) * PW'(dy_reg);
            pax_reg <= PW'(dx_reg) * PW'(ax_reg);
            pay_reg <= PW'(dy_reg) * PW'(ay_reg);
            pca_reg <= PW'(dx_reg) * PW'(ay_reg);
            pcb_reg <= PW'(dy_reg) * PW'(ax_reg);
            qax_reg <= PW'(ax_reg) * PW'(ax_reg);
            qay_reg <= PW'(ay_reg) * PW'(ay_reg);
            qbx_reg <= PW'(bx_reg) * PW'(bx_reg);
            qby_reg <= PW'(by_reg) * PW'(by_reg);
        end
    end

    // stage 3: sums
    logic signed [SW-1:0] len2_reg, dot_reg, cr_reg, da2_reg, db2_reg;

    always_ff @(posedge aclk) begin
        if (rdy[2] && vin[2]) begin
            len2_reg <= SW'(pdx_reg) + SW'(pdy_reg);
            dot_reg  <= SW'(pax_reg) + SW'(pay_reg);
            cr_reg   <= SW'(pca_reg) - SW'(pcb_reg);
            da2_reg  <= SW'(qax_reg) + SW'(qay_reg);
            db2_reg  <= SW'(qbx_reg) + SW'(qby_reg);
        end
    end

    // stage 4: case decision
    kind_t           kind_next, kind4_reg;
    logic [SW-1:0]   cr_abs;
    logic [HI-1:0]   hi_reg;
    logic [LO-1:0]   lo_reg;
    logic [LW-1:0]   d2_next, d2_4_reg, den_next, den4_reg;

    always_comb begin
        cr_abs = (cr_reg < 0) ? SW'(-cr_reg) : SW'(cr_reg);
        if (len2_reg == '0) begin
            kind_next = KIND_DEGEN;
        end else if (dot_reg <= 0) begin
            kind_next = KIND_START;
        end else if (dot_reg >= len2_reg) begin
            kind_next = KIND_END;
        end else begin
            kind_next = KIND_INTERIOR;
        end
        d2_next  = (kind_next == KIND_END) ? db2_reg[LW-1:0] : da2_reg[LW-1:0];
        den_next = (kind_next == KIND_INTERIOR) ? len2_reg[LW-1:0] : LW'(1);
    end

    always_ff @(posedge aclk) begin
        if (rdy[3] && vin[3]) begin
            kind4_reg <= kind_next;
            hi_reg    <= cr_abs[CRW-1:LO];
            lo_reg    <= cr_abs[LO-1:0];
            d2_4_reg  <= d2_next;
            den4_reg  <= den_next;
        end
    end

    // stage 5: partial products of the cross term squared
    kind_t                kind5_reg;
    logic [2*HI-1:0]      hh_reg;
    logic [HI+LO-1:0]     hl_reg;
    logic [2*LO-1:0]      ll_reg;
    logic [LW-1:0]        d2_5_reg, den5_reg;

    always_ff @(posedge aclk) begin
        if (rdy[4] && vin[4]) begin
            kind5_reg <= kind4_reg;
            hh_reg    <= (2*HI)'(hi_reg) * (2*HI)'(hi_reg);
            hl_reg    <= (HI+LO)'(hi_reg) * (HI+LO)'(lo_reg);
            ll_reg    <= (2*LO)'(lo_reg) * (2*LO)'(lo_reg);
            d2_5_reg  <= d2_4_reg;
            den5_reg  <= den4_reg;
        end
    end

    // stage 6: numerator, scaled and split for the divider
    logic [NBW-1:0] nb;
    logic [NW-1:0]  num;

    always_comb begin
        if (kind5_reg == KIND_INTERIOR) begin
            nb = (NBW'(hh_reg) << (2 * LO)) + (NBW'(hl_reg) << (LO + 1)) + NBW'(ll_reg);
        end else begin
            nb = NBW'(d2_5_reg);
        end
        num = NW'(nb) << (2 * FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (rdy[5] && vin[5]) begin
            out_rem  <= num[NW-1:QW];
            out_work <= num[QW-1:0];
            out_den  <= den5_reg;
            out_kind <= kind5_reg;
        end
    end

endmodule

// File: hdl/psd_div_cell.sv
module psd_div_cell import psd_pkg::*; #(
    parameter int LW = 34,
    parameter int QW = 51
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [LW-1:0] in_rem,
    input  logic [QW-1:0] in_work,
    input  logic [LW-1:0] in_den,
    input  kind_t         in_kind,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [LW-1:0] out_rem,
    output logic [QW-1:0] out_work,
    output logic [LW-1:0] out_den,
    output kind_t         out_kind
);

    logic          v_reg;
    logic [LW:0]   r2, diff;
    logic          ge;

    // one restoring step: shift in the next dividend bit, take out the divisor
    always_comb begin
        r2   = {in_rem, in_work[QW-1]};
        diff = r2 - {1'b0, in_den};
        ge   = (r2 >= {1'b0, in_den});
    end

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            out_rem  <= ge ? diff[LW-1:0] : r2[LW-1:0];
            out_work <= {in_work[QW-2:0], ge};
            out_den  <= in_den;
            out_kind <= in_kind;
        end
    end

endmodule

// File: hdl/psd_sqrt_cell.sv
module psd_sqrt_cell import psd_pkg::*; #(
    parameter int RW = 26
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [RW:0]     in_rem,
    input  logic [RW-1:0]   in_root,
    input  logic [2*RW-1:0] in_rad,
    input  kind_t           in_kind,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [RW:0]     out_rem,
    output logic [RW-1:0]   out_root,
    output logic [2*RW-1:0] out_rad,
    output kind_t           out_kind
);

    logic          v_reg;
    logic [RW+2:0] r4, trial, diff;
    logic          ge;

    // one root bit per cell from the next two radicand bits
    always_comb begin
        r4    = {in_rem, in_rad[2*RW-1 -: 2]};
        trial = {1'b0, in_root, 2'b01};
        diff  = r4 - trial;
        ge    = (r4 >= trial);
    end

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            out_rem  <= ge ? diff[RW:0] : r4[RW:0];
            out_root <= {in_root[RW-2:0], ge};
            out_rad  <= {in_rad[2*RW-3:0], 2'b00};
            out_kind <= in_kind;
        end
    end

endmodule

// File: hdl/point_segment_distance.sv
// Stages: six front stages, one divider cell per quotient bit,
// one square root cell per root bit.
// Throughput: one transfer per cycle while m_tready is high;
// every cell takes a new item each cycle while its output is not stalled.
// Reset: aresetn low clears all valid flags synchronously; the data path is not reset.
module point_segment_distance import psd_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int S_W = ((6 * COORD_BITS + 7) / 8) * 8,
    parameter int M_W = ((COORD_BITS + 1 + FRAC_BITS + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y, query_x, query_y
    input  logic [S_W-1:0] s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    // dist_q8
    output logic [M_W-1:0] m_tdata,
    // nearest_case
    output logic [1:0]     m_tuser
);

    localparam int C  = COORD_BITS;
    localparam int LW = 2 * C + 2;
    localparam int QW = 2 * C + 3 + 2 * FRAC_BITS;
    localparam int RW = C + 2 + FRAC_BITS;
    localparam int DB = C + 1 + FRAC_BITS;

    logic          d_v   [0:QW];
    logic          d_r   [0:QW];
    logic [LW-1:0] d_rem [0:QW];
    logic [QW-1:0] d_wrk [0:QW];
    logic [LW-1:0] d_den [0:QW];
    kind_t         d_knd [0:QW];

    logic            q_v    [0:RW];
    logic            q_r    [0:RW];
    logic [RW:0]     q_rem  [0:RW];
    logic [RW-1:0]   q_root [0:RW];
    logic [2*RW-1:0] q_rad  [0:RW];
    kind_t           q_knd  [0:RW];

    psd_front #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .LW        (LW),
        .QW        (QW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sx       (s_tdata[0*C +: C]),
        .sy       (s_tdata[1*C +: C]),
        .ex       (s_tdata[2*C +: C]),
        .ey       (s_tdata[3*C +: C]),
        .px       (s_tdata[4*C +: C]),
        .py       (s_tdata[5*C +: C]),
        .out_valid(d_v[0]),
        .out_ready(d_r[0]),
        .out_rem  (d_rem[0]),
        .out_work (d_wrk[0]),
        .out_den  (d_den[0]),
        .out_kind (d_knd[0])
    );

    for (genvar i = 0; i < QW; i++) begin : g_div
        psd_div_cell #(.LW(LW), .QW(QW)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (d_v[i]),
            .in_ready (d_r[i]),
            .in_rem   (d_rem[i]),
            .in_work  (d_wrk[i]),
            .in_den   (d_den[i]),
            .in_kind  (d_knd[i]),
            .out_valid(d_v[i+1]),
            .out_ready(d_r[i+1]),
            .out_rem  (d_rem[i+1]),
            .out_work (d_wrk[i+1]),
            .out_den  (d_den[i+1]),
            .out_kind (d_knd[i+1])
        );
    end

    // quotient becomes the radicand
    assign q_v[0]    = d_v[QW];
    assign d_r[QW]   = q_r[0];
    assign q_rem[0]  = '0;
    assign q_root[0] = '0;
    assign q_rad[0]  = (2*RW)'(d_wrk[QW]);
    assign q_knd[0]  = d_knd[QW];

    for (genvar i = 0; i < RW; i++) begin : g_sqrt
        psd_sqrt_cell #(.RW(RW)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (q_v[i]),
            .in_ready (q_r[i]),
            .in_rem   (q_rem[i]),
            .in_root  (q_root[i]),
            .in_rad   (q_rad[i]),
            .in_kind  (q_knd[i]),
            .out_valid(q_v[i+1]),
            .out_ready(q_r[i+1]),
            .out_rem  (q_rem[i+1]),
            .out_root (q_root[i+1]),
            .out_rad  (q_rad[i+1]),
            .out_kind (q_knd[i+1])
        );
    end

    assign m_tvalid  = q_v[RW];
    assign q_r[RW]   = m_tready;
    assign m_tdata   = M_W'(q_root[RW][DB-1:0]);
    assign m_tuser   = q_knd[RW];

    // an empty output stage frees the whole chain
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_sink_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while sink ready");

    a_reset_clear: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid after reset");

endmodule
